@@ rtl/ssscc_pkg.sv @@
// shared types, codes and constants of the servo sweep and stepper controller
package ssscc_pkg;

	// event codes on the input channel
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_SERVO = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_POS   = 2'd0;
	localparam logic [1:0] KIND_SPEED = 2'd1;
	localparam logic [1:0] KIND_COILS = 2'd2;

	// command framing and command keys
	localparam logic [7:0] CMD_END     = 8'hE0;
	localparam logic [7:0] CMD_POT     = 8'h50;
	localparam logic [7:0] CMD_HOLD    = 8'h53;
	localparam logic [7:0] CMD_SWEEP   = 8'h41;
	localparam logic [7:0] CMD_MOTOR   = 8'h4D;
	localparam logic [7:0] CMD_FORWARD = 8'h44;
	localparam logic [7:0] CMD_REVERSE = 8'h49;
	localparam logic [7:0] CMD_CANCEL  = 8'h43;

	// sweep phases
	localparam logic [1:0] PH_RESET = 2'd0;
	localparam logic [1:0] PH_OPEN  = 2'd1;
	localparam logic [1:0] PH_PAUSE = 2'd2;
	localparam logic [1:0] PH_CLOSE = 2'd3;

	// angle in twentieths of a degree
	localparam logic [10:0] FULL_ANGLE = 11'd1800;
	localparam logic [7:0]  MAX_DEG    = 8'd90;
	localparam logic [12:0] STEP_MAX   = 13'd8191;

	// reciprocal constants: deg = (a/4)*205 >> 10, pulse = 5a*14564 >> 17
	localparam int          MUL_B_W     = 14;
	localparam logic [13:0] DEG_RECIP   = 14'd205;
	localparam int          DEG_SHIFT   = 10;
	localparam logic [13:0] PULSE_RECIP = 14'd14564;
	localparam int          PULSE_SHIFT = 17;
	localparam logic [10:0] PULSE_BASE  = 11'd1000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  value;
		logic [10:0] pulse_us;
		logic [3:0]  coils;
		logic        last;
	} res_t;

	// two-coil full-step pattern, bit0 first coil
	function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
		logic [3:0] c;
		case (ph)
			2'd0:    c = 4'h3;
			2'd1:    c = 4'h6;
			2'd2:    c = 4'hC;
			default: c = 4'h9;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/ssscc_mul.sv @@
// shared multiplier with registered product
module ssscc_mul #(
	parameter int A_W = 23,
	parameter int B_W = 14
) (
	input  logic               clk,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] p
);

	logic [A_W+B_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

	assign p = p_q;

endmodule

@@ rtl/ssscc_outreg.sv @@
// output register of the result channel
module ssscc_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ssscc_pkg::res_t   d,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [7:0]        value,
	output logic [10:0]       pulse_us,
	output logic [3:0]        coils,
	output logic              last
);

	logic            valid_q;
	ssscc_pkg::res_t res_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= d;
		end
	end

	assign out_valid = valid_q;
	assign kind      = res_q.kind;
	assign value     = res_q.value;
	assign pulse_us  = res_q.pulse_us;
	assign coils     = res_q.coils;
	assign last      = res_q.last;

endmodule

@@ rtl/ssscc_core.sv @@
// command decode, servo and stepper state, and the step sequencer
module ssscc_core #(
	parameter int ADC_BITS = 12,
	parameter int A_W      = ADC_BITS + 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      op,
	input  logic [7:0]                      rx_byte,
	input  logic [11:0]                     pot_sample,
	output logic [A_W-1:0]                  mul_a,
	output logic [ssscc_pkg::MUL_B_W-1:0]   mul_b,
	input  logic [A_W+ssscc_pkg::MUL_B_W-1:0] mul_p,
	input  logic                            out_free,
	output logic                            out_load,
	output ssscc_pkg::res_t                 out_res
);

	localparam int BW       = ssscc_pkg::MUL_B_W;
	localparam int SAMPLE_W = (ADC_BITS > 12) ? ADC_BITS : 12;
	localparam longint FULL = (longint'(1) << ADC_BITS) - 1;
	// floor(2^A_W / FULL): at most one short, fixed by one compare
	localparam longint POT_M = (longint'(1) << A_W) / FULL;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_DISPATCH = 11'b000_0000_0010,
		ST_POT_MUL1 = 11'b000_0000_0100,
		ST_POT_MUL2 = 11'b000_0000_1000,
		ST_POT_FIX  = 11'b000_0001_0000,
		ST_SWEEP    = 11'b000_0010_0000,
		ST_SW_SET   = 11'b000_0100_0000,
		ST_REP_DEG  = 11'b000_1000_0000,
		ST_REP_PUL  = 11'b001_0000_0000,
		ST_REP_FIN  = 11'b010_0000_0000,
		ST_EMIT     = 11'b100_0000_0000
	} state_t;

	state_t          state_q;
	logic [23:0]     window_q;
	logic            pot_q, hold_q, sweep_q;
	logic [1:0]      phase_q;
	logic [10:0]     angle_q;
	logic [12:0]     step_q;
	logic [7:0]      pause_q, speed_q, motor_q;
	logic            rev_q, run_q;
	logic [1:0]      coil_q;
	logic            pend_pot_q, pend_hold_q, pend_sweep_q;
	logic [ADC_BITS-1:0] sample_q;
	logic [A_W-1:0]  x_q;
	logic [7:0]      deg_q;
	ssscc_pkg::res_t res_q;

	logic                accept;
	logic [SAMPLE_W-1:0] sample_w;
	logic [7:0]          b0, b1, b2, hold_deg;
	logic [1:0]          coil_nx;
	logic [10:0]         q0, pot_angle, pulse;
	logic [A_W-1:0]      rem;
	logic [20:0]         d;
	logic                sweep_reports, last_pos;
	logic [12:0]         step_inc;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign sample_w = SAMPLE_W'(pot_sample);
	assign b0       = window_q[23:16];
	assign b1       = window_q[15:8];
	assign b2       = window_q[7:0];
	assign hold_deg = (b1 > ssscc_pkg::MAX_DEG) ? ssscc_pkg::MAX_DEG : b1;
	assign coil_nx  = rev_q ? coil_q - 2'd1 : coil_q + 2'd1;

	// pot scaling correction: remainder against full scale
	assign q0  = mul_p[A_W +: 11];
	assign rem = x_q - ((A_W'(q0) << ADC_BITS) - A_W'(q0));
	assign pot_angle = (rem >= A_W'(FULL)) ? q0 + 11'd1 : q0;

	assign d        = mul_p[20:0];
	assign pulse    = ssscc_pkg::PULSE_BASE + mul_p[ssscc_pkg::PULSE_SHIFT +: 11];
	assign step_inc = (step_q != ssscc_pkg::STEP_MAX) ? step_q + 13'd1 : step_q;

	// whether a pending sweep step will itself report
	assign sweep_reports = ((phase_q == ssscc_pkg::PH_OPEN) && (angle_q < ssscc_pkg::FULL_ANGLE))
		|| (((phase_q == ssscc_pkg::PH_RESET) || (phase_q == ssscc_pkg::PH_CLOSE))
			&& (angle_q != 11'd0));
	assign last_pos = !pend_hold_q && !(pend_sweep_q && sweep_reports);

	// shared multiplier operands
	always_comb begin
		mul_a = A_W'(step_q);
		mul_b = BW'(speed_q);
		case (state_q)
			ST_POT_MUL1: begin
				mul_a = A_W'(sample_q);
				mul_b = BW'(ssscc_pkg::FULL_ANGLE);
			end
			ST_POT_MUL2: begin
				mul_a = mul_p[A_W-1:0];
				mul_b = BW'(POT_M);
			end
			ST_REP_DEG: begin
				mul_a = A_W'(angle_q[10:2]);
				mul_b = ssscc_pkg::DEG_RECIP;
			end
			ST_REP_PUL: begin
				mul_a = A_W'({angle_q, 2'b00}) + A_W'(angle_q);
				mul_b = ssscc_pkg::PULSE_RECIP;
			end
			default: begin
				mul_a = A_W'(step_q);
				mul_b = BW'(speed_q);
			end
		endcase
	end

	assign out_load = (state_q == ST_EMIT) && out_free;
	assign out_res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_q     <= '0;
			pot_q        <= 1'b0;
			hold_q       <= 1'b0;
			sweep_q      <= 1'b0;
			phase_q      <= ssscc_pkg::PH_RESET;
			angle_q      <= '0;
			step_q       <= '0;
			pause_q      <= '0;
			speed_q      <= '0;
			motor_q      <= '0;
			rev_q        <= 1'b0;
			run_q        <= 1'b0;
			coil_q       <= 2'd0;
			pend_pot_q   <= 1'b0;
			pend_hold_q  <= 1'b0;
			pend_sweep_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							ssscc_pkg::OP_BYTE: begin
								window_q <= {window_q[15:0], rx_byte};
								if (rx_byte == ssscc_pkg::CMD_END) begin
									case (b0)
										ssscc_pkg::CMD_POT: begin
											hold_q <= 1'b0;
											pot_q  <= 1'b1;
										end
										ssscc_pkg::CMD_HOLD: begin
											pot_q   <= 1'b0;
											hold_q  <= 1'b1;
											angle_q <= {hold_deg[6:0], 4'b0000}
												+ {2'b00, hold_deg[6:0], 2'b00};
										end
										ssscc_pkg::CMD_SWEEP: begin
											hold_q  <= 1'b0;
											pot_q   <= 1'b0;
											sweep_q <= 1'b1;
											pause_q <= b1;
											speed_q <= b2;
											phase_q <= ssscc_pkg::PH_RESET;
										end
										ssscc_pkg::CMD_MOTOR: begin
											motor_q <= b1;
											run_q   <= (b1 != 8'd0);
											res_q   <= '{kind: ssscc_pkg::KIND_SPEED,
												value: b1, pulse_us: 11'd0,
												coils: 4'd0, last: 1'b1};
											state_q <= ST_EMIT;
										end
										ssscc_pkg::CMD_FORWARD: rev_q <= 1'b0;
										ssscc_pkg::CMD_REVERSE: rev_q <= 1'b1;
										ssscc_pkg::CMD_CANCEL: begin
											pot_q   <= 1'b0;
											hold_q  <= 1'b0;
											sweep_q <= 1'b0;
											run_q   <= 1'b0;
										end
										default: ;
									endcase
								end
							end
							ssscc_pkg::OP_SERVO: begin
								sample_q     <= sample_w[ADC_BITS-1:0];
								pend_pot_q   <= pot_q;
								pend_hold_q  <= hold_q;
								pend_sweep_q <= sweep_q;
								state_q      <= ST_DISPATCH;
							end
							ssscc_pkg::OP_STEP: begin
								if (run_q) begin
									coil_q  <= coil_nx;
									res_q   <= '{kind: ssscc_pkg::KIND_COILS,
										value: 8'd0, pulse_us: 11'd0,
										coils: ssscc_pkg::coil_pattern(coil_nx),
										last: 1'b1};
									state_q <= ST_EMIT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DISPATCH: begin
					if (pend_pot_q) begin
						pend_pot_q <= 1'b0;
						state_q    <= ST_POT_MUL1;
					end else if (pend_hold_q) begin
						pend_hold_q <= 1'b0;
						state_q     <= ST_REP_DEG;
					end else if (pend_sweep_q) begin
						pend_sweep_q <= 1'b0;
						state_q      <= ST_SWEEP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_POT_MUL1: state_q <= ST_POT_MUL2;
				ST_POT_MUL2: begin
					x_q     <= mul_p[A_W-1:0];
					state_q <= ST_POT_FIX;
				end
				ST_POT_FIX: begin
					angle_q <= pot_angle;
					state_q <= ST_REP_DEG;
				end
				ST_SWEEP: begin
					case (phase_q)
						ssscc_pkg::PH_RESET: begin
							if (angle_q == 11'd0) begin
								step_q  <= '0;
								phase_q <= ssscc_pkg::PH_OPEN;
								state_q <= ST_DISPATCH;
							end else begin
								angle_q <= '0;
								state_q <= ST_REP_DEG;
							end
						end
						ssscc_pkg::PH_OPEN: begin
							if (angle_q < ssscc_pkg::FULL_ANGLE) begin
								state_q <= ST_SW_SET;
							end else begin
								phase_q <= ssscc_pkg::PH_PAUSE;
								step_q  <= {1'b0, pause_q, 4'b0000}
									+ {3'b000, pause_q, 2'b00};
								state_q <= ST_DISPATCH;
							end
						end
						ssscc_pkg::PH_PAUSE: begin
							if (step_q == 13'd0) begin
								phase_q <= ssscc_pkg::PH_CLOSE;
							end else begin
								step_q <= step_q - 13'd1;
							end
							state_q <= ST_DISPATCH;
						end
						default: begin
							if (angle_q != 11'd0) begin
								state_q <= ST_SW_SET;
							end else begin
								phase_q <= ssscc_pkg::PH_RESET;
								sweep_q <= 1'b0;
								state_q <= ST_DISPATCH;
							end
						end
					endcase
				end
				ST_SW_SET: begin
					if (phase_q == ssscc_pkg::PH_OPEN) begin
						angle_q <= (d > 21'(ssscc_pkg::FULL_ANGLE))
							? ssscc_pkg::FULL_ANGLE : d[10:0];
					end else begin
						angle_q <= (d >= 21'(ssscc_pkg::FULL_ANGLE))
							? 11'd0 : ssscc_pkg::FULL_ANGLE - d[10:0];
					end
					step_q  <= step_inc;
					state_q <= ST_REP_DEG;
				end
				ST_REP_DEG: state_q <= ST_REP_PUL;
				ST_REP_PUL: begin
					deg_q   <= mul_p[ssscc_pkg::DEG_SHIFT +: 8];
					state_q <= ST_REP_FIN;
				end
				ST_REP_FIN: begin
					res_q   <= '{kind: ssscc_pkg::KIND_POS, value: deg_q,
						pulse_us: pulse, coils: 4'd0, last: last_pos};
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_DISPATCH;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_q <= ssscc_pkg::FULL_ANGLE)
		else $error("servo angle beyond full travel");

	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(pot_q && hold_q))
		else $error("pot and hold mode both on");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !out_free) |=> (state_q == ST_EMIT))
		else $error("result dropped while output busy");

	a_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == ssscc_pkg::OP_STEP && run_q)
		|=> (state_q == ST_EMIT && res_q.kind == ssscc_pkg::KIND_COILS))
		else $error("stepper tick gave no coil beat");
`endif

endmodule

@@ rtl/servo_sweep_stepper_command_controller_top.sv @@
// top level of the servo sweep and stepper command controller
//
// input channel (in_valid / in_stall): one beat per event; op selects a
// received serial byte, a 50 ms servo tick or a stepper tick. rx_byte is
// used on a byte, pot_sample on a servo tick in pot mode.
// result channel (out_valid / out_stall): kind, value, pulse_us, coils and
// last; last marks the final beat caused by one input beat.
// timing: in_stall is low only while the sequencer is idle. a command byte
// or stepper tick with a result passes decode, emit and dispatch; one
// without a result is taken in decode alone. a servo tick passes decode and
// dispatch, then for each position report the degree and pulse products, a
// finishing step, an emit and a return to dispatch, plus two products and a
// correction for pot scaling and a sweep step and set for each sweep step.
// the sequencer feeds all these products through the shared multiplier.
// a finished beat waits in the output register; the next input beat is
// taken meanwhile, and the sequencer holds in its emit step only when a
// second beat is ready before the first has gone.
// reset (arst_n low) clears all modes, the byte window, the sweep, the
// angle and the motor; the coil drive restarts at phase one.
module servo_sweep_stepper_command_controller_top #(
	parameter int ADC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	input  logic [11:0] pot_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [10:0] pulse_us,
	output logic [3:0]  coils,
	output logic        last
);

	// multiplier operand a holds the pot product sample*1800
	localparam int A_W = ADC_BITS + 11;
	localparam int B_W = ssscc_pkg::MUL_B_W;

	logic [A_W-1:0]     mul_a;
	logic [B_W-1:0]     mul_b;
	logic [A_W+B_W-1:0] mul_p;
	logic               out_free;
	logic               out_load;
	ssscc_pkg::res_t    out_res;

	// sequencer with command decode and all servo and stepper state
	ssscc_core #(
		.ADC_BITS (ADC_BITS),
		.A_W      (A_W)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.rx_byte    (rx_byte),
		.pot_sample (pot_sample),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.mul_p      (mul_p),
		.out_free   (out_free),
		.out_load   (out_load),
		.out_res    (out_res)
	);

	// the one multiplier, shared by pot scaling, sweep steps and reports
	ssscc_mul #(
		.A_W (A_W),
		.B_W (B_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// result beat register, parts the sequencer from the receiver
	ssscc_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.d         (out_res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.pulse_us  (pulse_us),
		.coils     (coils),
		.last      (last)
	);

endmodule

@@ tb/sv/tb_servo_sweep_stepper_command_controller_top.sv @@
`timescale 1ns / 1ps
// testbench of the servo sweep and stepper command controller: every result beat checked
module tb_servo_sweep_stepper_command_controller_top;

	localparam int          ADC_W         = 12;
	localparam int          ADC_FULL      = (1 << ADC_W) - 1;
	localparam int          ANGLE_TOP     = 1800;
	localparam logic [1:0]  OP_UNUSED     = 2'd3;
	// coil drive per phase, phase one in the low nibble
	localparam logic [15:0] COIL_SEQ      = 16'h9C63;
	localparam int          RANDOM_BEATS  = 1750;
	localparam int          QUIET_STRETCH = 250;
	localparam int          SETTLE_CYCLES = 24;
	localparam int          LONG_HOLD     = 400;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  op         = ssscc_pkg::OP_BYTE;
	logic [7:0]  rx_byte    = 8'd0;
	logic [11:0] pot_sample = 12'd0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  value;
	logic [10:0] pulse_us;
	logic [3:0]  coils;
	logic        last;

	// own copy of the controller state
	logic [23:0] rx_window  = 24'd0;
	logic        pot_on     = 1'b0;
	logic        hold_on    = 1'b0;
	logic        sweep_on   = 1'b0;
	logic        motor_on   = 1'b0;
	logic        reverse_on = 1'b0;
	logic [1:0]  sweep_ph   = ssscc_pkg::PH_RESET;
	logic [1:0]  coil_ph    = 2'd0;
	int          angle      = 0;
	int          steps      = 0;
	int          pause_s    = 0;
	int          sweep_spd  = 0;

	ssscc_pkg::res_t outputs_due[$];

	logic idle_on    = 1'b1;
	int   hold_off   = 0;
	int   errors     = 0;
	int   checked    = 0;
	int   beats_sent = 0;
	int   sweeps_done = 0;

	servo_sweep_stepper_command_controller_top #(
		.ADC_BITS(ADC_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx_byte(rx_byte),
		.pot_sample(pot_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.value(value),
		.pulse_us(pulse_us),
		.coils(coils),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// position report from the current angle
	function automatic ssscc_pkg::res_t position_beat();
		ssscc_pkg::res_t r;
		r = '0;
		r.kind = ssscc_pkg::KIND_POS;
		r.value = 8'(angle / 20);
		r.pulse_us = 11'(int'(ssscc_pkg::PULSE_BASE) + angle * 5 / 9);
		return r;
	endfunction

	// advances the controller state by one input beat and queues the beats it causes
	function automatic void step_controller(input logic [1:0] e_op, input logic [7:0] e_byte,
			input logic [11:0] e_sample);
		ssscc_pkg::res_t made[$];
		ssscc_pkg::res_t r;
		logic [7:0]      key;
		logic [7:0]      arg1;
		logic [7:0]      arg2;
		int              d;
		key = rx_window[23:16];
		arg1 = rx_window[15:8];
		arg2 = rx_window[7:0];
		if (e_op == ssscc_pkg::OP_BYTE) begin
			rx_window = {rx_window[15:0], e_byte};
			if (e_byte == ssscc_pkg::CMD_END) begin
				case (key)
					ssscc_pkg::CMD_POT: begin
						hold_on = 1'b0;
						pot_on = 1'b1;
					end
					ssscc_pkg::CMD_HOLD: begin
						pot_on = 1'b0;
						hold_on = 1'b1;
						angle = 20 * ((arg1 > ssscc_pkg::MAX_DEG)
							? int'(ssscc_pkg::MAX_DEG) : int'(arg1));
					end
					ssscc_pkg::CMD_SWEEP: begin
						pot_on = 1'b0;
						hold_on = 1'b0;
						sweep_on = 1'b1;
						pause_s = int'(arg1);
						sweep_spd = int'(arg2);
						sweep_ph = ssscc_pkg::PH_RESET;
					end
					ssscc_pkg::CMD_MOTOR: begin
						motor_on = (arg1 != 8'd0);
						r = '0;
						r.kind = ssscc_pkg::KIND_SPEED;
						r.value = arg1;
						made.push_back(r);
					end
					ssscc_pkg::CMD_FORWARD: reverse_on = 1'b0;
					ssscc_pkg::CMD_REVERSE: reverse_on = 1'b1;
					ssscc_pkg::CMD_CANCEL: begin
						pot_on = 1'b0;
						hold_on = 1'b0;
						sweep_on = 1'b0;
						motor_on = 1'b0;
					end
					default: ;
				endcase
			end
		end else if (e_op == ssscc_pkg::OP_SERVO) begin
			if (pot_on) begin
				angle = (int'(e_sample) & ADC_FULL) * ANGLE_TOP / ADC_FULL;
				made.push_back(position_beat());
			end
			if (hold_on) made.push_back(position_beat());
			if (sweep_on) begin
				case (sweep_ph)
					ssscc_pkg::PH_RESET: begin
						if (angle == 0) begin
							steps = 0;
							sweep_ph = ssscc_pkg::PH_OPEN;
						end else begin
							angle = 0;
							made.push_back(position_beat());
						end
					end
					ssscc_pkg::PH_OPEN: begin
						if (angle < ANGLE_TOP) begin
							d = steps * sweep_spd;
							angle = (d > ANGLE_TOP) ? ANGLE_TOP : d;
							made.push_back(position_beat());
							if (steps < int'(ssscc_pkg::STEP_MAX)) steps++;
						end else begin
							sweep_ph = ssscc_pkg::PH_PAUSE;
							steps = pause_s * 20;
						end
					end
					ssscc_pkg::PH_PAUSE: begin
						if (steps == 0) sweep_ph = ssscc_pkg::PH_CLOSE;
						else steps--;
					end
					default: begin
						if (angle > 0) begin
							d = steps * sweep_spd;
							angle = (d >= ANGLE_TOP) ? 0 : ANGLE_TOP - d;
							made.push_back(position_beat());
							if (steps < int'(ssscc_pkg::STEP_MAX)) steps++;
						end else begin
							sweep_ph = ssscc_pkg::PH_RESET;
							sweep_on = 1'b0;
							sweeps_done++;
						end
					end
				endcase
			end
		end else if (e_op == ssscc_pkg::OP_STEP) begin
			if (motor_on) begin
				coil_ph = reverse_on ? coil_ph - 2'd1 : coil_ph + 2'd1;
				r = '0;
				r.kind = ssscc_pkg::KIND_COILS;
				r.coils = COIL_SEQ[4 * coil_ph +: 4];
				made.push_back(r);
			end
		end
		// the final beat of this input carries last
		for (int i = 0; i < made.size(); i++) begin
			r = made[i];
			r.last = (i == made.size() - 1);
			outputs_due.push_back(r);
		end
	endfunction

	// offers one beat, with a random gap in front when idling is on
	task automatic send_event(input logic [1:0] e_op, input logic [7:0] e_byte,
			input logic [11:0] e_sample);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			gap = $urandom_range(3, 1);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= e_op;
		rx_byte <= e_byte;
		pot_sample <= e_sample;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		step_controller(e_op, e_byte, e_sample);
		beats_sent++;
	endtask

	task automatic send_tick(input logic [1:0] e_op);
		send_event(e_op, 8'($urandom), 12'($urandom));
	endtask

	// key, two arguments, then the closing byte
	task automatic send_command(input logic [7:0] key, input logic [7:0] arg1,
			input logic [7:0] arg2);
		send_event(ssscc_pkg::OP_BYTE, key, 12'($urandom));
		send_event(ssscc_pkg::OP_BYTE, arg1, 12'($urandom));
		send_event(ssscc_pkg::OP_BYTE, arg2, 12'($urandom));
		send_event(ssscc_pkg::OP_BYTE, ssscc_pkg::CMD_END, 12'($urandom));
	endtask

	// sender waits until every predicted beat has come out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outputs_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// nothing enabled: ticks and an unused op give no result
	task automatic test_quiet_events();
		send_tick(ssscc_pkg::OP_SERVO);
		send_tick(ssscc_pkg::OP_STEP);
		send_tick(OP_UNUSED);
		settle();
	endtask

	// speed zero echoes but leaves the stepper stopped, then both directions
	task automatic test_motor_drive();
		send_command(ssscc_pkg::CMD_MOTOR, 8'd0, 8'd0);
		send_tick(ssscc_pkg::OP_STEP);
		send_command(ssscc_pkg::CMD_MOTOR, 8'hFF, 8'hFF);
		send_tick(ssscc_pkg::OP_STEP);
		send_command(ssscc_pkg::CMD_REVERSE, 8'h00, 8'h00);
		send_tick(ssscc_pkg::OP_STEP);
		send_tick(ssscc_pkg::OP_STEP);
		settle();
	endtask

	// hold clamps at ninety degrees, pot at both ends of the converter, then cancel
	task automatic test_hold_and_pot();
		send_command(ssscc_pkg::CMD_HOLD, 8'hFF, 8'h00);
		send_tick(ssscc_pkg::OP_SERVO);
		send_command(ssscc_pkg::CMD_POT, 8'h00, 8'h00);
		send_event(ssscc_pkg::OP_SERVO, 8'h00, 12'hFFF);
		send_event(ssscc_pkg::OP_SERVO, 8'hFF, 12'h000);
		send_command(ssscc_pkg::CMD_CANCEL, 8'h00, 8'h00);
		send_tick(ssscc_pkg::OP_SERVO);
		settle();
	endtask

	// receiver holds off while coil beats keep coming, so the block backs up
	task automatic test_output_backpressure();
		send_command(ssscc_pkg::CMD_MOTOR, 8'($urandom_range(255, 1)), 8'($urandom));
		settle();
		hold_off = LONG_HOLD;
		repeat (40) send_tick(ssscc_pkg::OP_STEP);
		settle();
	endtask

	// random sessions of well-formed commands and ticks, with some noise between
	task automatic test_random_sessions(input int n_beats);
		int start;
		int skipped;
		int mark;
		int pick;
		int pause;
		int speed;
		int cap;
		int n;
		start = beats_sent;
		skipped = 0;
		idle_on = 1'b0;
		while (beats_sent - start - skipped < n_beats) begin
			// long stretch without idling first
			idle_on = (beats_sent - start >= QUIET_STRETCH);
			pick = $urandom_range(99);
			if (pick < 25) begin
				pick = $urandom_range(99);
				if (pick < 10) speed = $urandom_range(255);
				else if (pick < 25) speed = $urandom_range(29, 5);
				else speed = $urandom_range(255, 30);
				pause = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
				send_command(ssscc_pkg::CMD_SWEEP, 8'(pause), 8'(speed));
				// pot and sweep both report on one tick
				if ($urandom_range(3) == 0)
					send_command(ssscc_pkg::CMD_POT, 8'($urandom), 8'($urandom));
				cap = 200;
				while (sweep_on && cap > 0) begin
					pick = $urandom_range(99);
					if (pick < 85) send_tick(ssscc_pkg::OP_SERVO);
					else if (pick < 95) send_tick(ssscc_pkg::OP_STEP);
					else send_tick(OP_UNUSED);
					cap--;
				end
			end else if (pick < 40) begin
				if ($urandom_range(1))
					send_command(ssscc_pkg::CMD_HOLD, 8'($urandom_range(100)),
						8'($urandom));
				else
					send_command(ssscc_pkg::CMD_HOLD, 8'($urandom), 8'($urandom));
				n = $urandom_range(4, 1);
				repeat (n) send_tick(ssscc_pkg::OP_SERVO);
			end else if (pick < 55) begin
				send_command(ssscc_pkg::CMD_POT, 8'($urandom), 8'($urandom));
				n = $urandom_range(6, 1);
				repeat (n) send_tick(ssscc_pkg::OP_SERVO);
				if ($urandom_range(9) < 3)
					send_command(ssscc_pkg::CMD_CANCEL, 8'($urandom), 8'($urandom));
			end else if (pick < 75) begin
				speed = ($urandom_range(99) < 15) ? 0 : $urandom_range(255, 1);
				send_command(ssscc_pkg::CMD_MOTOR, 8'(speed), 8'($urandom));
				if ($urandom_range(1)) begin
					if ($urandom_range(1))
						send_command(ssscc_pkg::CMD_FORWARD, 8'($urandom),
							8'($urandom));
					else
						send_command(ssscc_pkg::CMD_REVERSE, 8'($urandom),
							8'($urandom));
				end
				n = $urandom_range(8, 1);
				repeat (n) send_tick(ssscc_pkg::OP_STEP);
			end else if (pick < 92) begin
				// noise: stray bytes, unused ops, unknown keys, broken frames
				mark = beats_sent;
				n = $urandom_range(4, 1);
				repeat (n) begin
					case ($urandom_range(3))
						0: send_event(ssscc_pkg::OP_BYTE, 8'($urandom), 12'($urandom));
						1: send_tick(OP_UNUSED);
						2: begin
							case ($urandom_range(2))
								0: send_command(8'h54, 8'($urandom), 8'($urandom));
								1: send_command(8'h58, 8'($urandom), 8'($urandom));
								default: send_command(8'($urandom), 8'($urandom),
									8'($urandom));
							endcase
						end
						default: begin
							send_event(ssscc_pkg::OP_BYTE, ssscc_pkg::CMD_SWEEP,
								12'($urandom));
							send_event(ssscc_pkg::OP_BYTE, 8'($urandom), 12'($urandom));
							send_tick(ssscc_pkg::OP_SERVO);
						end
					endcase
				end
				skipped += beats_sent - mark;
			end else if (pick < 97) begin
				send_command(ssscc_pkg::CMD_CANCEL, 8'($urandom), 8'($urandom));
			end else begin
				settle();
			end
		end
		idle_on = 1'b1;
	endtask

	// receiver: random stalls, or a counted hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off = hold_off - 1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 30);
		end
	end

	// every accepted result beat against the oldest prediction
	always @(posedge clk) begin
		ssscc_pkg::res_t seen;
		ssscc_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {kind, value, pulse_us, coils, last};
			if (outputs_due.size() == 0) begin
				$display("%0t: beat with nothing due: kind %0d value %0d pulse %0d %s",
					$time, seen.kind, seen.value, seen.pulse_us,
					$sformatf("coils %h last %0d", seen.coils, seen.last));
				errors++;
			end else begin
				want = outputs_due.pop_front();
				if (seen.kind !== want.kind || seen.value !== want.value
						|| seen.pulse_us !== want.pulse_us || seen.coils !== want.coils
						|| seen.last !== want.last) begin
					$display("%0t: mismatch expected kind %0d value %0d pulse %0d %s",
						$time, want.kind, want.value, want.pulse_us,
						$sformatf("coils %h last %0d", want.coils, want.last));
					$display("%0t:          actual kind %0d value %0d pulse %0d %s",
						$time, seen.kind, seen.value, seen.pulse_us,
						$sformatf("coils %h last %0d", seen.coils, seen.last));
					errors++;
				end
				checked++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d result beats still due", outputs_due.size());
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_quiet_events();
		test_motor_drive();
		test_hold_and_pot();
		test_output_backpressure();
		test_random_sessions(RANDOM_BEATS);
		settle();
		$display("%0d input beats of bytes, commands and ticks; %0d result beats compared",
			beats_sent, checked);
		$display("%0d sweeps ran through open, pause and close to the end", sweeps_done);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
